// ===== rtl/core/c2d_pkg.sv =====
package c2d_pkg;

   localparam int KERNEL        = 4;
   localparam int MAX_WIDTH     = 1024;
   localparam int PIXEL_BITS    = 16;

   localparam int IN_BITS       = 16;
   localparam int COEF_BITS     = 16;
   localparam int NUM_COEF_ROWS = 4;
   localparam int OUT_BITS      = 36;

   localparam int TAPS          = KERNEL - 1;
   localparam int LINE_BITS     = TAPS * PIXEL_BITS;
   localparam int COL_BITS      = $clog2(MAX_WIDTH);
   localparam int PROD_BITS     = PIXEL_BITS + COEF_BITS;
   localparam int CSUM_BITS     = PROD_BITS + $clog2(KERNEL);

   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_IDX_BITS   = 3;
   localparam int WIDTH_REG_BITS = 11;
   localparam int CLAMP_BITS     = (WIDTH_REG_BITS > COL_BITS + 1) ?
                                   WIDTH_REG_BITS : COL_BITS + 1;
   localparam int COEF_IDX_BITS  = $clog2(NUM_COEF_ROWS);

   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COEF_ROW0   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COEF_ROW3   = 3'd4;

   typedef logic signed [PIXEL_BITS-1:0] pixel_type;
   typedef logic signed [COEF_BITS-1:0]  coef_type;
   typedef logic signed [CSUM_BITS-1:0]  csum_type;

   typedef struct packed {
      logic shift;
      logic prod;
      logic sum;
   } cell_ctrl_type;

endpackage

// ===== rtl/core/conv2d_valid_sliding_window.sv =====
// Valid-mode, stride-one 2D correlation of a square image with a 4x4 Q4.12
// filter. Pixels stream in raster order; one pixel is taken per clock when
// rsp_stall is low. Each result is the full 36-bit sum of window products
// with twelve fractional bits; rsp_frame_last marks the last result of a
// frame and the next frame may follow without a gap. The window is a row of
// four column cells that shift left per pixel and each own four 16x16
// multipliers; earlier rows come from a single-port-per-side line store, so
// the rate is one pixel per clock. Width and coefficients must be written
// only while the block is idle; the block itself does not enforce this.
module conv2d_valid_sliding_window
   import c2d_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [IN_BITS-1:0]       req_pixel,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [OUT_BITS-1:0]      rsp_conv_value,
   output logic                            rsp_frame_last,
   input  logic                            csr_write,
   input  logic [CSR_IDX_BITS-1:0]         csr_index,
   input  logic [CSR_DATA_BITS-1:0]        csr_wdata
);

   // configuration
   logic [COL_BITS-1:0]      width_last_ff, width_last_in;
   logic [CSR_DATA_BITS-1:0] coef_rows_ff [NUM_COEF_ROWS];
   logic [CLAMP_BITS-1:0]    wr_width;
   logic [COEF_IDX_BITS-1:0] coef_sel;

   always_comb begin
      wr_width = CLAMP_BITS'(csr_wdata[WIDTH_REG_BITS-1:0]);
      if (wr_width < CLAMP_BITS'(KERNEL)) begin
         wr_width = CLAMP_BITS'(KERNEL);
      end else if (wr_width > CLAMP_BITS'(MAX_WIDTH)) begin
         wr_width = CLAMP_BITS'(MAX_WIDTH);
      end
      width_last_in = COL_BITS'(wr_width - CLAMP_BITS'(1));
      coef_sel      = COEF_IDX_BITS'(csr_index - CSR_COEF_ROW0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff <= COL_BITS'(MAX_WIDTH - 1);
         for (int i = 0; i < NUM_COEF_ROWS; i++) begin
            coef_rows_ff[i] <= '0;
         end
      end else if (csr_write) begin
         if (csr_index == CSR_IMAGE_WIDTH) begin
            width_last_ff <= width_last_in;
         end else if (csr_index >= CSR_COEF_ROW0 && csr_index <= CSR_COEF_ROW3) begin
            coef_rows_ff[coef_sel] <= csr_wdata;
         end
      end
   end

   // pipeline handshake
   logic ready_out, ready4, ready3, ready2, ready1;
   logic fire, en2, en3, en4, en_out;
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, rsp_valid_ff;
   logic s1_v_in, s2_v_in, s3_v_in, s4_v_in, rsp_valid_in;

   always_comb begin
      ready_out = ~rsp_valid_ff | ~rsp_stall;
      en_out    = s4_v_ff & ready_out;
      ready4    = ~s4_v_ff | ready_out;
      en4       = s3_v_ff & ready4;
      ready3    = ~s3_v_ff | ready4;
      en3       = s2_v_ff & ready3;
      ready2    = ~s2_v_ff | ready3;
      en2       = s1_v_ff & ready2;
      ready1    = ~s1_v_ff | ready2;
      fire      = req_valid & ready1;
   end

   assign req_stall = ~ready1;

   // position counters
   logic [COL_BITS-1:0] col_ff, col_in, row_ff, row_in;
   logic                at_col_end, at_row_end, produce, last;

   always_comb begin
      at_col_end = col_ff >= width_last_ff;
      at_row_end = row_ff >= width_last_ff;
      produce    = (col_ff >= COL_BITS'(KERNEL - 1)) && (row_ff >= COL_BITS'(KERNEL - 1));
      last       = at_col_end & at_row_end;
      col_in     = col_ff;
      row_in     = row_ff;
      if (fire) begin
         if (at_col_end) begin
            col_in = '0;
            row_in = at_row_end ? '0 : row_ff + COL_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   // stage flags and payload
   pixel_type           s1_pixel_ff;
   logic [COL_BITS-1:0] s1_col_ff;
   logic                s1_prod_ff, s1_last_ff;
   logic                s2_prod_ff, s2_last_ff;
   logic                s3_prod_ff, s3_last_ff;
   logic                s4_prod_ff, s4_last_ff;
   logic signed [OUT_BITS-1:0] total_in, rsp_conv_value_ff;
   logic                rsp_frame_last_ff;

   always_comb begin
      s1_v_in      = fire | (s1_v_ff & ~en2);
      s2_v_in      = en2  | (s2_v_ff & ~en3);
      s3_v_in      = en3  | (s3_v_ff & ~en4);
      s4_v_in      = en4  | (s4_v_ff & ~en_out);
      rsp_valid_in = en_out ? s4_prod_ff : (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         s4_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s2_v_in;
         s3_v_ff      <= s3_v_in;
         s4_v_ff      <= s4_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         s1_pixel_ff <= req_pixel[PIXEL_BITS-1:0];
         s1_col_ff   <= col_ff;
         s1_prod_ff  <= produce;
         s1_last_ff  <= last;
      end
      if (en2) begin
         s2_prod_ff <= s1_prod_ff;
         s2_last_ff <= s1_last_ff;
      end
      if (en3) begin
         s3_prod_ff <= s2_prod_ff;
         s3_last_ff <= s2_last_ff;
      end
      if (en4) begin
         s4_prod_ff <= s3_prod_ff;
         s4_last_ff <= s3_last_ff;
      end
      if (en_out) begin
         rsp_conv_value_ff <= total_in;
         rsp_frame_last_ff <= s4_last_ff;
      end
   end

   // line store: read on accept, write back the shifted column as it leaves s1
   logic [LINE_BITS-1:0] line_rd, line_wr;
   pixel_type            new_col [KERNEL];

   c2d_line_buf u_line_buf (
      .clock   (clock),
      .rd_en   (fire),
      .rd_addr (col_ff),
      .rd_data (line_rd),
      .wr_en   (en2),
      .wr_addr (s1_col_ff),
      .wr_data (line_wr)
   );

   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         new_col[i] = line_rd[i*PIXEL_BITS +: PIXEL_BITS];
      end
      new_col[KERNEL-1] = s1_pixel_ff;
      for (int i = 0; i < TAPS; i++) begin
         line_wr[i*PIXEL_BITS +: PIXEL_BITS] = new_col[i+1];
      end
   end

   // window cells
   cell_ctrl_type cell_ctrl;
   pixel_type     cell_col  [KERNEL][KERNEL];
   coef_type      cell_coef [KERNEL][KERNEL];
   csum_type      cell_sum  [KERNEL];

   always_comb begin
      cell_ctrl.shift = en2;
      cell_ctrl.prod  = en3;
      cell_ctrl.sum   = en4;
      for (int j = 0; j < KERNEL; j++) begin
         for (int i = 0; i < KERNEL; i++) begin
            cell_coef[j][i] = coef_rows_ff[i][COEF_BITS*j +: COEF_BITS];
         end
      end
   end

   for (genvar j = 0; j < KERNEL; j++) begin : g_cell
      if (j == KERNEL - 1) begin : g_edge
         c2d_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctrl    (cell_ctrl),
            .col_in  (new_col),
            .col_out (cell_col[j]),
            .coef    (cell_coef[j]),
            .col_sum (cell_sum[j])
         );
      end else begin : g_inner
         c2d_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctrl    (cell_ctrl),
            .col_in  (cell_col[j+1]),
            .col_out (cell_col[j]),
            .coef    (cell_coef[j]),
            .col_sum (cell_sum[j])
         );
      end
   end

   always_comb begin
      total_in = '0;
      for (int j = 0; j < KERNEL; j++) begin
         total_in = total_in + OUT_BITS'(cell_sum[j]);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_conv_value = rsp_conv_value_ff;
   assign rsp_frame_last = rsp_frame_last_ff;

endmodule

// ===== rtl/core/c2d_line_buf.sv =====
module c2d_line_buf
   import c2d_pkg::*;
(
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [COL_BITS-1:0]  rd_addr,
   output logic [LINE_BITS-1:0] rd_data,
   input  logic                 wr_en,
   input  logic [COL_BITS-1:0]  wr_addr,
   input  logic [LINE_BITS-1:0] wr_data
);

   logic [LINE_BITS-1:0] mem [MAX_WIDTH];
   logic [LINE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/c2d_cell.sv =====
module c2d_cell
   import c2d_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  pixel_type     col_in  [KERNEL],
   output pixel_type     col_out [KERNEL],
   input  coef_type      coef    [KERNEL],
   output csum_type      col_sum
);

   pixel_type                    win_ff  [KERNEL];
   pixel_type                    win_in  [KERNEL];
   logic signed [PROD_BITS-1:0]  prod_ff [KERNEL];
   logic signed [PROD_BITS-1:0]  prod_in [KERNEL];
   csum_type                     sum_ff;
   csum_type                     sum_in;

   always_comb begin
      for (int i = 0; i < KERNEL; i++) begin
         win_in[i]  = ctrl.shift ? col_in[i] : win_ff[i];
         prod_in[i] = PROD_BITS'(win_ff[i]) * PROD_BITS'(coef[i]);
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < KERNEL; i++) begin
         sum_in = sum_in + CSUM_BITS'(prod_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KERNEL; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < KERNEL; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.prod) begin
         for (int i = 0; i < KERNEL; i++) begin
            prod_ff[i] <= prod_in[i];
         end
      end
      if (ctrl.sum) begin
         sum_ff <= sum_in;
      end
   end

   assign col_out = win_ff;
   assign col_sum = sum_ff;

endmodule

// ===== tb/tb_conv2d_valid_sliding_window.sv =====
module tb_conv2d_valid_sliding_window;
   import c2d_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 9;
   localparam int SETTLE       = 16;
   localparam int TOTAL_ITEMS  = 1100;
   localparam int BURST_PIXELS = 48;
   localparam int LONG_HOLD    = 400;
   localparam int IDLE_PCT     = 32;
   localparam int MAX_REPORTS  = 100;
   localparam int TIMEOUT      = 2 * HALF_PERIOD * 500000;

   localparam logic [CSR_IDX_BITS-1:0] CSR_COEF_ROW1 = CSR_COEF_ROW0 + 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COEF_ROW2 = CSR_COEF_ROW0 + 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE     = CSR_COEF_ROW3 + 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOP       = '1;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] value;
      logic                       last;
   } conv_beat_type;

   typedef enum logic {ROW_CSR, ROW_PIX} row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic [CSR_IDX_BITS-1:0]  idx;
      logic [CSR_DATA_BITS-1:0] data;
      pixel_type                pix;
      logic [7:0]               count;
      logic                     typed;
      conv_beat_type            want;
   } plan_row_type;

   logic                       clock;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [IN_BITS-1:0]  req_pixel = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [OUT_BITS-1:0] rsp_conv_value;
   logic                       rsp_frame_last;
   logic                       csr_write = 1'b0;
   logic [CSR_IDX_BITS-1:0]    csr_index = '0;
   logic [CSR_DATA_BITS-1:0]   csr_wdata = '0;

   // predictor state
   logic [WIDTH_REG_BITS-1:0]  width_reg;
   logic [CSR_DATA_BITS-1:0]   coef_reg [NUM_COEF_ROWS];
   pixel_type                  line_mem [MAX_WIDTH][TAPS];
   pixel_type                  win [KERNEL][KERNEL];
   int unsigned                col_cnt;
   int unsigned                row_cnt;
   conv_beat_type              pending_sums [$];

   int  idle_pct     = IDLE_PCT;
   bit  hold_ask     = 1'b0;
   int  errors       = 0;
   int  pixels_sent  = 0;
   int  results_seen = 0;
   int  csr_writes   = 0;

   plan_row_type plan [9];

   conv2d_valid_sliding_window dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_conv_value (rsp_conv_value),
      .rsp_frame_last (rsp_frame_last),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   initial begin
      #TIMEOUT;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic int unsigned active_width();
      int unsigned w;
      w = width_reg;
      if (w < KERNEL) w = KERNEL;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic pixel_type rand_pixel();
      case ($urandom_range(0, 15))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'shFFFF;
         default: return pixel_type'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] rand_coef_row();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return {4{16'h8000}};
         2: return {4{16'h7FFF}};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] width_word(int unsigned wv);
      return {$urandom, 21'($urandom), WIDTH_REG_BITS'(wv)};
   endfunction

   task automatic window_sum_predict(input pixel_type px, output bit made,
                                     output conv_beat_type beat);
      int unsigned w, c, r, col;
      pixel_type column [KERNEL];
      logic signed [OUT_BITS-1:0] acc, a, b;
      bit col_end, row_end;
      w = active_width();
      c = col_cnt;
      r = row_cnt;
      col = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
      col_end = (c >= w - 1);
      row_end = (r >= w - 1);
      for (int i = 0; i < TAPS; i++) column[i] = line_mem[col][i];
      column[KERNEL-1] = px;
      for (int i = 0; i < TAPS; i++) line_mem[col][i] = column[i+1];
      for (int i = 0; i < KERNEL; i++) begin
         for (int j = 0; j < KERNEL - 1; j++) win[i][j] = win[i][j+1];
         win[i][KERNEL-1] = column[i];
      end
      made = 1'b0;
      beat = '0;
      if (r >= KERNEL - 1 && c >= KERNEL - 1) begin
         acc = '0;
         for (int i = 0; i < KERNEL; i++) begin
            for (int j = 0; j < KERNEL; j++) begin
               a = win[i][j];
               b = coef_type'(coef_reg[i][COEF_BITS*j +: COEF_BITS]);
               acc = acc + a * b;
            end
         end
         beat.value = acc;
         beat.last = col_end && row_end;
         made = 1'b1;
      end
      if (col_end) begin
         col_cnt = 0;
         row_cnt = row_end ? 0 : r + 1;
      end else begin
         col_cnt = c + 1;
      end
   endtask

   task automatic send_pixel(input pixel_type px, input bit typed,
                             input conv_beat_type want);
      bit made;
      conv_beat_type beat;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      window_sum_predict(px, made, beat);
      if (made) pending_sums.push_back(typed ? want : beat);
      pixels_sent++;
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_store(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH)
         width_reg = data[WIDTH_REG_BITS-1:0];
      else if (idx >= CSR_COEF_ROW0 && idx <= CSR_COEF_ROW3)
         coef_reg[idx - CSR_COEF_ROW0] = data;
      csr_writes++;
      @(posedge clock);
   endtask

   // check each result beat against the oldest pending sum
   initial begin
      int hold_left;
      conv_beat_type want;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_sums.size() == 0) begin
               if (errors < MAX_REPORTS)
                  $display("%0t: unexpected result, expected none, got value %0d last %0b",
                           $time, rsp_conv_value, rsp_frame_last);
               errors++;
            end else begin
               want = pending_sums.pop_front();
               results_seen++;
               if (rsp_conv_value !== want.value) begin
                  if (errors < MAX_REPORTS)
                     $display("%0t: conv_value expected %0d got %0d",
                              $time, want.value, rsp_conv_value);
                  errors++;
               end
               if (rsp_frame_last !== want.last) begin
                  if (errors < MAX_REPORTS)
                     $display("%0t: frame_last expected %0b got %0b",
                              $time, want.last, rsp_frame_last);
                  errors++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_ask) begin
            hold_ask = 1'b0;
            hold_left = LONG_HOLD;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < idle_pct);
         end
      end
   end

   initial begin
      int unsigned w, wv;
      int phase, goal, n;
      bit whole;

      width_reg = WIDTH_REG_BITS'(MAX_WIDTH);
      foreach (coef_reg[i]) coef_reg[i] = '0;
      foreach (line_mem[i, j]) line_mem[i][j] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      col_cnt = 0;
      row_cnt = 0;
      phase = 0;

      // width field zero clamps to the kernel size; coefficients still at reset
      plan = '{
         '{ROW_CSR, CSR_IMAGE_WIDTH, 64'hFFFF_FFFF_FFFF_F800, 16'sh0, 8'd0, 1'b0,
           '{36'sh0, 1'b0}},
         '{ROW_PIX, CSR_IMAGE_WIDTH, 64'h0, 16'sh8000, 8'd8, 1'b0, '{36'sh0, 1'b0}},
         '{ROW_PIX, CSR_IMAGE_WIDTH, 64'h0, 16'sh7FFF, 8'd8, 1'b1, '{36'sh0, 1'b1}},
         '{ROW_CSR, CSR_TOP, 64'hFFFF_FFFF_FFFF_FFFF, 16'sh0, 8'd0, 1'b0, '{36'sh0, 1'b0}},
         '{ROW_CSR, CSR_COEF_ROW0, {4{16'h8000}}, 16'sh0, 8'd0, 1'b0, '{36'sh0, 1'b0}},
         '{ROW_CSR, CSR_COEF_ROW1, {4{16'h8000}}, 16'sh0, 8'd0, 1'b0, '{36'sh0, 1'b0}},
         '{ROW_CSR, CSR_COEF_ROW2, {4{16'h8000}}, 16'sh0, 8'd0, 1'b0, '{36'sh0, 1'b0}},
         '{ROW_CSR, CSR_COEF_ROW3, {4{16'h8000}}, 16'sh0, 8'd0, 1'b0, '{36'sh0, 1'b0}},
         '{ROW_PIX, CSR_IMAGE_WIDTH, 64'h0, 16'sh8000, 8'd16, 1'b1,
           '{36'sh4_0000_0000, 1'b1}}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[k]) begin
         if (plan[k].kind == ROW_CSR) begin
            quiesce();
            csr_store(plan[k].idx, plan[k].data);
         end else begin
            for (int i = 0; i < plan[k].count; i++)
               send_pixel(plan[k].pix, plan[k].typed && (i == plan[k].count - 1), plan[k].want);
         end
      end

      // one full-width row and a few pixels (width field saturates), then shrink mid-frame
      quiesce();
      csr_store(CSR_IMAGE_WIDTH, width_word((1 << WIDTH_REG_BITS) - 1));
      for (int k = 0; k < NUM_COEF_ROWS; k++)
         csr_store(CSR_IDX_BITS'(CSR_COEF_ROW0 + k), rand_coef_row());
      repeat (MAX_WIDTH + KERNEL) send_pixel(rand_pixel(), 1'b0, '0);
      quiesce();
      csr_store(CSR_IMAGE_WIDTH, width_word($urandom_range(0, KERNEL)));
      do send_pixel(rand_pixel(), 1'b0, '0);
      while (col_cnt != 0 || row_cnt != 0);

      while (phase < 4 || pixels_sent < TOTAL_ITEMS) begin
         phase++;
         quiesce();
         for (int k = 0; k < NUM_COEF_ROWS; k++)
            if (phase == 1 || $urandom_range(0, 1))
               csr_store(CSR_IDX_BITS'(CSR_COEF_ROW0 + k), rand_coef_row());
         if ($urandom_range(0, 7) == 0)
            csr_store(CSR_IDX_BITS'($urandom_range(CSR_SPARE, CSR_TOP)), {$urandom, $urandom});
         if ($urandom_range(0, 2) != 0) begin
            // widening is only safe at a frame boundary
            if (col_cnt == 0 && row_cnt == 0) begin
               case ($urandom_range(0, 9))
                  8: wv = $urandom_range(0, KERNEL - 1);
                  9: wv = $urandom_range(10, 16);
                  default: wv = $urandom_range(KERNEL, 9);
               endcase
            end else begin
               wv = $urandom_range(0, active_width());
            end
            csr_store(CSR_IMAGE_WIDTH, width_word(wv));
         end
         idle_pct = (phase == 4) ? 0 : IDLE_PCT;
         hold_ask = (phase == 2);
         w = active_width();
         whole = (phase == 2 || phase == 4 || $urandom_range(0, 9) < 7);
         goal = (phase == 2 || phase == 4) ? BURST_PIXELS :
                $urandom_range(1, whole ? w * w : w);
         n = 0;
         do begin
            send_pixel(rand_pixel(), 1'b0, '0);
            n++;
         end while (n < goal || (whole && (col_cnt != 0 || row_cnt != 0)));
      end

      quiesce();
      $display("Streamed %0d pixels over %0d setting phases and %0d register writes,",
               pixels_sent, phase + 3, csr_writes);
      $display("checked %0d sums incl. clamped widths, a 1024-wide row and mid-frame shrink",
               results_seen);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
